>>> src/fit_pkg.sv
// ----------------------------------------------------------------------------
// fit_pkg
// Shared types and constants for the frame interval tracker: beat payloads,
// the mid-pipeline record and the timestamp conversion constants.
// ----------------------------------------------------------------------------
package fit_pkg;

    // input beat: one video frame
    typedef struct packed {
        logic [63:0]        dequeue_start_ms;
        logic [63:0]        dequeue_finish_ms;
        logic signed [63:0] capture_sec;
        logic signed [31:0] capture_usec;
    } fit_in_t;

    // result beat
    typedef struct packed {
        logic        timing_valid;
        logic        order_error;
        logic [31:0] wait_ms;
        logic [31:0] capture_gap_ms;
        logic [31:0] loop_gap_ms;
    } fit_out_t;

    // frame after conversion, ahead of the interval update
    typedef struct packed {
        logic        reject;
        logic [31:0] wait_ms;
        logic [63:0] finish_ms;
        logic [63:0] capture_ms;
    } fit_mid_t;

    // microsecond field limit, exclusive
    localparam logic [31:0] USEC_LIMIT   = 32'd1_000_000;
    // bits needed for a legal microsecond count
    localparam int          USEC_W       = 20;
    // floor(usec / 1000) == (usec * MS_DIV_RECIP) >> MS_DIV_SHIFT for usec < 2**20
    localparam int          MS_DIV_SHIFT = 30;
    localparam int          RECIP_W      = 21;
    localparam logic [RECIP_W-1:0] MS_DIV_RECIP = 21'd1073742;
    localparam int          PROD_W       = USEC_W + RECIP_W;
    // millisecond part is at most 999
    localparam int          MS_W         = 10;
    // seconds times 1000 needs ten bits above the 64-bit range
    localparam int          STAMP_W      = 74;

endpackage

>>> src/fit_stamp_conv.sv
// ----------------------------------------------------------------------------
// fit_stamp_conv
// Turns a capture timestamp in seconds and microseconds into milliseconds,
// giving zero for a negative, out of range or overflowing stamp.
// ----------------------------------------------------------------------------
module fit_stamp_conv (
    input  logic signed [63:0] capture_sec,
    input  logic signed [31:0] capture_usec,
    output logic [63:0]        capture_ms
);
    import fit_pkg::*;

    logic                 usec_ok;
    logic [PROD_W-1:0]    usec_prod;
    logic [MS_W-1:0]      ms_part;
    logic [STAMP_W-1:0]   sec_ext;
    logic [STAMP_W-1:0]   sec_x1000;
    logic [STAMP_W-1:0]   stamp_sum;

    // microseconds must be non-negative and below one second
    assign usec_ok = !capture_usec[31] && (unsigned'(capture_usec) < USEC_LIMIT);

    // usec / 1000 by reciprocal multiply
    assign usec_prod = {{RECIP_W{1'b0}}, capture_usec[USEC_W-1:0]}
                     * {{USEC_W{1'b0}}, MS_DIV_RECIP};
    assign ms_part   = usec_prod[MS_DIV_SHIFT +: MS_W];

    // seconds * 1000 as 1024 - 16 - 8
    assign sec_ext   = {{(STAMP_W-64){1'b0}}, capture_sec};
    assign sec_x1000 = (sec_ext << 10) - (sec_ext << 4) - (sec_ext << 3);
    assign stamp_sum = sec_x1000 + {{(STAMP_W-MS_W){1'b0}}, ms_part};

    // zero for a bad stamp or one that does not fit 64 bits
    assign capture_ms = (!capture_sec[63] && usec_ok && (stamp_sum[STAMP_W-1:64] == '0))
                      ? stamp_sum[63:0] : 64'd0;

endmodule

>>> src/frame_interval_tracker.sv
// ----------------------------------------------------------------------------
// frame_interval_tracker
// Frame timing monitor: dequeue wait, capture interval and loop interval.
// ----------------------------------------------------------------------------
// Pipeline: an input beat passes through the input register, the conversion
//   register and the result register, in that order.
// Throughput: one frame per cycle unless m_ready stalls; the interval update
//   against the last frame is a compare and subtract at the result register.
// Reset: synchronous, active low; clears pipeline valids, history and gaps.
module frame_interval_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fit_pkg::fit_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fit_pkg::fit_out_t m_data
);
    import fit_pkg::*;

    fit_in_t     a_reg;
    logic        a_valid_reg;
    fit_mid_t    b_reg;
    fit_mid_t    b_next;
    logic        b_valid_reg;
    fit_out_t    m_data_reg;
    fit_out_t    m_data_next;
    logic        m_valid_reg;

    logic [63:0] prev_capture_reg;
    logic [63:0] prev_capture_next;
    logic [63:0] prev_finish_reg;
    logic [63:0] prev_finish_next;
    logic        have_capture_reg;
    logic        have_capture_next;
    logic        have_finish_reg;
    logic        have_finish_next;
    logic [31:0] wait_reg;
    logic [31:0] wait_next;
    logic [31:0] capture_gap_reg;
    logic [31:0] capture_gap_next;
    logic [31:0] loop_gap_reg;
    logic [31:0] loop_gap_next;

    logic        c_load;
    logic        b_load;
    logic        a_load;
    logic [63:0] conv_ms;
    logic [63:0] wait_diff;
    logic [63:0] cap_diff;
    logic [63:0] loop_diff;
    logic        cap_fresh;
    logic        loop_fresh;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // stage advance: each register moves when the one after it has room
    assign c_load  = b_valid_reg && (!m_valid_reg || m_ready);
    assign b_load  = a_valid_reg && (!b_valid_reg || !m_valid_reg || m_ready);
    assign a_load  = s_valid && s_ready;
    assign s_ready = !a_valid_reg || !b_valid_reg || !m_valid_reg || m_ready;

    // capture stamp to milliseconds
    fit_stamp_conv u_conv (
        .capture_sec  (a_reg.capture_sec),
        .capture_usec (a_reg.capture_usec),
        .capture_ms   (conv_ms)
    );

    // order check and dequeue wait
    always_comb begin
        wait_diff          = a_reg.dequeue_finish_ms - a_reg.dequeue_start_ms;
        b_next.reject      = a_reg.dequeue_finish_ms < a_reg.dequeue_start_ms;
        b_next.wait_ms     = sat32(wait_diff);
        b_next.finish_ms   = a_reg.dequeue_finish_ms;
        b_next.capture_ms  = conv_ms;
    end

    // interval update against the previous frame
    always_comb begin
        cap_diff   = b_reg.capture_ms - prev_capture_reg;
        loop_diff  = b_reg.finish_ms - prev_finish_reg;
        cap_fresh  = have_capture_reg && (b_reg.capture_ms > prev_capture_reg);
        loop_fresh = have_finish_reg && (b_reg.finish_ms >= prev_finish_reg);

        prev_capture_next = prev_capture_reg;
        prev_finish_next  = prev_finish_reg;
        have_capture_next = have_capture_reg;
        have_finish_next  = have_finish_reg;
        wait_next         = wait_reg;
        capture_gap_next  = capture_gap_reg;
        loop_gap_next     = loop_gap_reg;

        if (b_reg.reject) begin
            have_finish_next = 1'b0;
        end else begin
            wait_next = b_reg.wait_ms;
            if (b_reg.capture_ms == '0) begin
                have_capture_next = 1'b0;
            end else begin
                if (cap_fresh) begin
                    capture_gap_next = sat32(cap_diff);
                end
                prev_capture_next = b_reg.capture_ms;
                have_capture_next = 1'b1;
            end
            if (loop_fresh) begin
                loop_gap_next = sat32(loop_diff);
            end
            prev_finish_next = b_reg.finish_ms;
            have_finish_next = 1'b1;
        end

        m_data_next.timing_valid   = !b_reg.reject && cap_fresh && loop_fresh;
        m_data_next.order_error    = b_reg.reject;
        m_data_next.wait_ms        = wait_next;
        m_data_next.capture_gap_ms = capture_gap_next;
        m_data_next.loop_gap_ms    = loop_gap_next;
    end

    // pipeline valids and tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            prev_capture_reg <= '0;
            prev_finish_reg  <= '0;
            have_capture_reg <= 1'b0;
            have_finish_reg  <= 1'b0;
            wait_reg         <= '0;
            capture_gap_reg  <= '0;
            loop_gap_reg     <= '0;
        end else begin
            if (a_load) begin
                a_valid_reg <= 1'b1;
            end else if (b_load) begin
                a_valid_reg <= 1'b0;
            end
            if (b_load) begin
                b_valid_reg <= 1'b1;
            end else if (c_load) begin
                b_valid_reg <= 1'b0;
            end
            if (c_load) begin
                m_valid_reg      <= 1'b1;
                prev_capture_reg <= prev_capture_next;
                prev_finish_reg  <= prev_finish_next;
                have_capture_reg <= have_capture_next;
                have_finish_reg  <= have_finish_next;
                wait_reg         <= wait_next;
                capture_gap_reg  <= capture_gap_next;
                loop_gap_reg     <= loop_gap_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_reg <= s_data;
        end
        if (b_load) begin
            b_reg <= b_next;
        end
        if (c_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a rejected frame always drops the loop history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_load && b_reg.reject) |=> !have_finish_reg)
        else $error("loop history kept after order error");

    // a valid timing result implies both histories are present
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.timing_valid) |-> (have_capture_reg && have_finish_reg))
        else $error("timing valid without history");

    // a stalled result beat freezes the tracker state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(prev_finish_reg) && $stable(prev_capture_reg)))
        else $error("state moved while result stalled");

    // rejection and valid timing never coexist
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.order_error && m_data_reg.timing_valid))
        else $error("order error flagged with valid timing");

endmodule

>>> sim/frame_interval_tracker_tb.sv
// ----------------------------------------------------------------------------
// frame_interval_tracker_tb
// Self-checking bench for the frame interval tracker. Frames are pushed
// through the valid/ready input, each result beat is compared field by field
// against an in-bench prediction of the wait, capture and loop intervals.
// A directed run covers the edge cases, then random frame streams follow under
// three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module frame_interval_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fit_pkg::*;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          RANDOM_BEATS = 400;
    localparam logic [63:0] MS_PER_SEC   = 64'd1000;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    // largest second counts that still fit once scaled to milliseconds
    localparam logic [63:0] SEC_TOP      = 64'd18446744073709551;
    localparam logic [63:0] SEC_TOP_FULL = 64'd18446744073709550;

    // ------------------------------------------------------------------------
    // predicted interval state and queue of expected result beats
    // ------------------------------------------------------------------------
    class frame_gap_board;
        fit_out_t    expected_q[$];
        logic [63:0] last_capture_ms;
        logic [63:0] last_finish_ms;
        bit          capture_seen;
        bit          finish_seen;
        logic [31:0] wait_hold;
        logic [31:0] capture_gap_hold;
        logic [31:0] loop_gap_hold;
        int          mismatches;
        int          frames;
        int          checked;
        int          rejected;
        int          fresh;

        function new();
            last_capture_ms  = '0;
            last_finish_ms   = '0;
            capture_seen     = 1'b0;
            finish_seen      = 1'b0;
            wait_hold        = '0;
            capture_gap_hold = '0;
            loop_gap_hold    = '0;
            mismatches       = 0;
            frames           = 0;
            checked          = 0;
            rejected         = 0;
            fresh            = 0;
        endfunction

        function logic [31:0] clip32(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        // capture stamp in ms, zero for any stamp that is unusable
        function logic [63:0] stamp_ms(logic [63:0] sec, logic [31:0] usec);
            logic [63:0] ms_part;
            if (sec[63] || usec[31] || usec >= USEC_LIMIT)
                return '0;
            ms_part = {32'd0, usec} / MS_PER_SEC;
            if (sec > (ALL_ONES - ms_part) / MS_PER_SEC)
                return '0;
            return sec * MS_PER_SEC + ms_part;
        endfunction

        // accepted input beat: advance the prediction and queue the result
        function void note_frame(fit_in_t f);
            logic [63:0] cap;
            bit          cap_fresh;
            bit          loop_fresh;
            fit_out_t    e;
            e = '0;
            frames++;
            if (f.dequeue_finish_ms < f.dequeue_start_ms) begin
                finish_seen   = 1'b0;
                e.order_error = 1'b1;
                rejected++;
            end else begin
                wait_hold  = clip32(f.dequeue_finish_ms - f.dequeue_start_ms);
                cap        = stamp_ms(f.capture_sec, f.capture_usec);
                cap_fresh  = capture_seen && (cap > last_capture_ms);
                loop_fresh = finish_seen && (f.dequeue_finish_ms >= last_finish_ms);
                if (cap == '0) begin
                    capture_seen = 1'b0;
                end else begin
                    if (cap_fresh)
                        capture_gap_hold = clip32(cap - last_capture_ms);
                    last_capture_ms = cap;
                    capture_seen    = 1'b1;
                end
                if (loop_fresh)
                    loop_gap_hold = clip32(f.dequeue_finish_ms - last_finish_ms);
                last_finish_ms   = f.dequeue_finish_ms;
                finish_seen      = 1'b1;
                e.timing_valid   = cap_fresh && loop_fresh;
                if (e.timing_valid)
                    fresh++;
            end
            e.wait_ms        = wait_hold;
            e.capture_gap_ms = capture_gap_hold;
            e.loop_gap_ms    = loop_gap_hold;
            expected_q.push_back(e);
        endfunction

        // accepted result beat: compare against the oldest expectation
        function void check_result(fit_out_t got);
            fit_out_t e;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: beat arrived with nothing expected (%h)",
                             checked, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.timing_valid !== e.timing_valid || got.order_error !== e.order_error ||
                got.wait_ms !== e.wait_ms || got.capture_gap_ms !== e.capture_gap_ms ||
                got.loop_gap_ms !== e.loop_gap_ms) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected valid=%b err=%b wait=%h cap=%h loop=%h",
                             checked, e.timing_valid, e.order_error, e.wait_ms,
                             e.capture_gap_ms, e.loop_gap_ms);
                    $display("result %0d: actual   valid=%b err=%b wait=%h cap=%h loop=%h",
                             checked, got.timing_valid, got.order_error, got.wait_ms,
                             got.capture_gap_ms, got.loop_gap_ms);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    fit_in_t   s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    fit_out_t  m_data;

    int        send_idle_pct = 10;
    int        recv_idle_pct = 84;
    int        stall_cycles  = 0;

    // running time base for well-formed frame streams
    logic [63:0] run_finish = 64'd1000;
    logic [63:0] run_sec    = 64'd10;
    logic [31:0] run_usec   = 32'd0;

    frame_gap_board board = new();

    frame_interval_tracker uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always #5 aclk = ~aclk;

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result monitor and stall counter
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, board.pending());
        $display("Mismatches found");
        $finish;
    end

    function automatic fit_in_t make_frame(logic [63:0] start, logic [63:0] finish,
                                           logic [63:0] sec, logic [31:0] usec);
        fit_in_t f;
        f.dequeue_start_ms  = start;
        f.dequeue_finish_ms = finish;
        f.capture_sec       = sec;
        f.capture_usec      = usec;
        return f;
    endfunction

    // drive one input beat; called and returns on a falling edge
    task automatic send_frame(input fit_in_t f);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
        board.note_frame(f);
        @(negedge aclk);
    endtask

    // next random frame: mostly a well-formed stream, some broken frames and noise
    task automatic make_random_frame(output fit_in_t f);
        logic [63:0] start;
        logic [63:0] finish;
        int          pick;
        pick = $urandom_range(0, 99);

        // rebase the stream somewhere else in the 64-bit range
        if (pick >= 93 && pick < 95) begin
            run_finish = {$urandom, $urandom} >> $urandom_range(0, 40);
            run_sec    = {1'b0, 31'($urandom), 32'($urandom)} >> $urandom_range(0, 50);
        end

        // advance the stream
        start = run_finish + $urandom_range(0, 50);
        if ($urandom_range(0, 19) == 0)
            finish = start + {$urandom, $urandom};
        else
            finish = start + $urandom_range(0, 40);
        if ($urandom_range(0, 19) != 0)
            run_usec = run_usec + $urandom_range(0, 60000);
        if ($urandom_range(0, 29) == 0)
            run_sec = run_sec + $urandom_range(0, 5000000);
        while (run_usec >= USEC_LIMIT) begin
            run_usec = run_usec - USEC_LIMIT;
            run_sec  = run_sec + 64'd1;
        end
        f = make_frame(start, finish, run_sec, run_usec);

        if (pick >= 70 && pick < 80) begin
            // finish before start
            f.dequeue_finish_ms = start - 64'd1 - $urandom_range(0, 100);
        end else if (pick >= 80 && pick < 88) begin
            // unusable capture stamp
            case ($urandom_range(0, 4))
                0: f.capture_sec  = {1'b1, 31'($urandom), 32'($urandom)};
                1: f.capture_usec = {1'b1, 31'($urandom)};
                2: f.capture_usec = $urandom_range(USEC_LIMIT, 32'h7FFF_FFFF);
                3: begin
                    f.capture_sec  = SEC_TOP + $urandom_range(0, 1);
                    f.capture_usec = $urandom_range(616000, 999999);
                end
                default: begin
                    f.capture_sec  = '0;
                    f.capture_usec = $urandom_range(0, 999);
                end
            endcase
            run_finish = finish;
        end else if (pick >= 88 && pick < 93) begin
            // finish moving backwards
            f.dequeue_finish_ms = run_finish - $urandom_range(1, 100);
            f.dequeue_start_ms  = f.dequeue_finish_ms - $urandom_range(0, 20);
            run_finish          = f.dequeue_finish_ms;
        end else if (pick >= 95) begin
            // pure noise on every field
            f = make_frame({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, $urandom);
        end else begin
            run_finish = finish;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        fit_in_t f;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed edge cases
        send_frame(make_frame(64'd0, 64'd0, 64'd0, 32'd0));           // zero stamp
        send_frame(make_frame(64'd0, 64'd10, 64'd1, 32'd0));          // first capture
        send_frame(make_frame(64'd10, 64'd25, 64'd1, 32'd20000));     // both fresh
        send_frame(make_frame(64'd100, 64'd99, 64'd2, 32'd0));        // finish before start
        send_frame(make_frame(64'd30, 64'd40, 64'd1, 32'd999999));    // loop history lost
        send_frame(make_frame(64'd40, 64'd50, 64'd1, 32'd999999));    // capture not advancing
        send_frame(make_frame(64'd50, 64'd60, 64'd1, 32'd500000));    // capture backwards
        send_frame(make_frame(64'd20, 64'd45, 64'd3, 32'd0));         // finish backwards
        send_frame(make_frame(64'd45, 64'd45, ALL_ONES, 32'd0));      // negative seconds
        send_frame(make_frame(64'd45, 64'd46, 64'd4, 32'hFFFF_FFFF)); // negative usec
        send_frame(make_frame(64'd46, 64'd47, 64'd4, USEC_LIMIT));    // usec at limit
        send_frame(make_frame(64'd47, 64'd48, 64'd4, 32'h7FFF_FFFF)); // usec max
        send_frame(make_frame(64'd48, 64'd49, 64'h8000_0000_0000_0000, 32'd0));
        send_frame(make_frame(64'd49, 64'd50, 64'd5, 32'd0));
        send_frame(make_frame(64'd50, 64'd51, SEC_TOP_FULL, 32'd999999)); // huge gap
        send_frame(make_frame(64'd51, 64'd52, SEC_TOP, 32'd615999));      // top of range
        send_frame(make_frame(64'd52, 64'd53, SEC_TOP, 32'd616000));      // just overflows
        send_frame(make_frame(64'd53, 64'd54, SEC_TOP + 64'd1, 32'd0));
        send_frame(make_frame(64'd54, 64'd54 + 64'hFFFF_FFFF, 64'd6, 32'd0));
        send_frame(make_frame(64'd0, 64'h1_0000_0000, 64'd7, 32'd0));
        send_frame(make_frame(64'd0, ALL_ONES, 64'd8, 32'd0));            // saturated wait
        send_frame(make_frame(ALL_ONES, ALL_ONES, 64'd9, 32'd0));         // zero loop gap
        send_frame(make_frame(64'd500, 64'd520, 64'd9, 32'd30000));
        send_frame(make_frame(64'd520, 64'd530, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0));

        // random streams under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 10; recv_idle_pct = 84; end
                1: begin send_idle_pct = 84; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int i = 0; i < RANDOM_BEATS / 3; i++) begin
                make_random_frame(f);
                send_frame(f);
            end
        end
        s_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d frames driven, %0d rejected on order, %0d with both intervals fresh",
                 board.frames, board.rejected, board.fresh);
        $display("%0d result beats checked across three back-pressure mixes, %0d bad",
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
